@@ rtl/slat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slat_pkg;

	typedef enum logic [2:0] {
		OP_INSERT       = 3'd0,
		OP_DELETE       = 3'd1,
		OP_GET_BEFORE   = 3'd2,
		OP_GET_AFTER    = 3'd3,
		OP_RESET_BEFORE = 3'd4,
		OP_RESET_AFTER  = 3'd5
	} op_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_SHUP,
		ST_SHDN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] line_key;
		logic [15:0] before_in;
		logic [15:0] after_in;
	} in_t;

	typedef struct packed {
		logic        found;
		logic [15:0] count_out;
		logic        full_drop;
		logic [6:0]  entries_used;
	} out_t;

	typedef struct packed {
		logic [15:0] line_key;
		logic [15:0] before_cnt;
		logic [15:0] after_cnt;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/sorted_line_attribute_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted line attribute table: up to CAPACITY entries ordered by ascending line key.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// busy stays high until the result has been produced; one command at a time.
// Result channel: result is valid for exactly one cycle while strobe is high.
// The receiver cannot stall; a consumer must take the result in that cycle.
// Each valid command walks the entry RAM (one read, one write port) under a small sequencer:
//   lookup scan  : one RAM read per cycle, up to the first key not below the command key
//   insert shift : one entry moved per cycle, larger keys up, then the new entry written
//   delete shift : one entry moved per cycle, tail down (delete, or reset to all zero)
//   plus a dispatch state and a result state, then strobe the cycle after.
// The scan stops at the slot where an insert shift ends or a delete shift starts.
// The RAM ports and the one key comparator bound the rate.
// Reset clears the entry count and the sequencer; RAM contents are not cleared
// and are never read beyond the entry count. Unused op codes return a result
// with found, count_out and full_drop zero.

module sorted_line_attribute_table #(
	parameter int CAPACITY = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire slat_pkg::in_t  cmd,
	output logic                busy,
	output logic                strobe,
	output slat_pkg::out_t      result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	slat_pkg::state_t state_q, state_d;
	slat_pkg::in_t    cmd_q;
	slat_pkg::entry_t ent_q;
	slat_pkg::entry_t rdata;
	slat_pkg::out_t   res_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [AW-1:0] wa_q;
	logic          pend_q;
	logic          hit_q;
	logic          drop_q;
	logic          strobe_q;

	logic          issue;
	logic [CW-1:0] idx_nxt;
	logic          key_ge;
	logic          key_eq;
	logic          op_valid;

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	slat_pkg::entry_t wdata;

	slat_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared key comparator
	assign key_ge   = rdata.line_key >= cmd_q.line_key;
	assign key_eq   = rdata.line_key == cmd_q.line_key;
	assign op_valid = cmd.op <= slat_pkg::OP_RESET_AFTER;
	assign idx_nxt  = idx_q + CW'(1);

	always_comb begin
		case (state_q)
			slat_pkg::ST_SCAN: issue = idx_q < cnt_q;
			slat_pkg::ST_SHUP: issue = idx_q > pos_q;
			slat_pkg::ST_SHDN: issue = idx_nxt < cnt_q;
			default:           issue = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			slat_pkg::ST_IDLE: begin
				if (start) begin
					state_d = op_valid ? slat_pkg::ST_SCAN : slat_pkg::ST_FIN;
				end
			end
			slat_pkg::ST_SCAN: begin
				if ((pend_q && key_ge) || (!pend_q && !issue)) begin
					state_d = slat_pkg::ST_EXEC;
				end
			end
			slat_pkg::ST_EXEC: begin
				state_d = slat_pkg::ST_FIN;
				case (cmd_q.op)
					slat_pkg::OP_INSERT: begin
						if (!hit_q && cnt_q != CW'(CAPACITY)) begin
							state_d = slat_pkg::ST_SHUP;
						end
					end
					slat_pkg::OP_DELETE: begin
						if (hit_q) begin
							state_d = slat_pkg::ST_SHDN;
						end
					end
					slat_pkg::OP_RESET_BEFORE: begin
						if (hit_q && ent_q.after_cnt == 16'd0) begin
							state_d = slat_pkg::ST_SHDN;
						end
					end
					slat_pkg::OP_RESET_AFTER: begin
						if (hit_q && ent_q.before_cnt == 16'd0) begin
							state_d = slat_pkg::ST_SHDN;
						end
					end
					default: state_d = slat_pkg::ST_FIN;
				endcase
			end
			slat_pkg::ST_SHUP,
			slat_pkg::ST_SHDN: begin
				if (!pend_q && !issue) begin
					state_d = slat_pkg::ST_FIN;
				end
			end
			slat_pkg::ST_FIN: state_d = slat_pkg::ST_IDLE;
			default:          state_d = slat_pkg::ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			slat_pkg::ST_EXEC: begin
				waddr = pos_q[AW-1:0];
				wdata = ent_q;
				case (cmd_q.op)
					slat_pkg::OP_INSERT: begin
						we = hit_q;
						if (cmd_q.before_in != 16'd0) begin
							wdata.before_cnt = cmd_q.before_in;
						end
						if (cmd_q.after_in != 16'd0) begin
							wdata.after_cnt = cmd_q.after_in;
						end
					end
					slat_pkg::OP_RESET_BEFORE: begin
						we = hit_q && ent_q.after_cnt != 16'd0;
						wdata.before_cnt = 16'd0;
					end
					slat_pkg::OP_RESET_AFTER: begin
						we = hit_q && ent_q.before_cnt != 16'd0;
						wdata.after_cnt = 16'd0;
					end
					default: we = 1'b0;
				endcase
			end
			slat_pkg::ST_SHUP: begin
				raddr = idx_q[AW-1:0] - AW'(1);
				if (pend_q) begin
					we = 1'b1;
				end else if (!issue) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = '{line_key: cmd_q.line_key, before_cnt: cmd_q.before_in,
						after_cnt: cmd_q.after_in};
				end
			end
			slat_pkg::ST_SHDN: begin
				raddr = idx_nxt[AW-1:0];
				we    = pend_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= slat_pkg::ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
			hit_q    <= 1'b0;
			drop_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			case (state_q)
				slat_pkg::ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					hit_q  <= 1'b0;
					drop_q <= 1'b0;
				end
				slat_pkg::ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_nxt;
					end
					if (pend_q && key_ge) begin
						hit_q <= key_eq;
					end
				end
				slat_pkg::ST_EXEC: begin
					pend_q <= 1'b0;
					if (cmd_q.op == slat_pkg::OP_INSERT) begin
						idx_q  <= cnt_q;
						drop_q <= !hit_q && cnt_q == CW'(CAPACITY);
					end else begin
						idx_q <= pos_q;
					end
				end
				slat_pkg::ST_SHUP: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q - CW'(1);
					end else if (!pend_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				slat_pkg::ST_SHDN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_nxt;
					end else if (!pend_q) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				slat_pkg::ST_FIN: strobe_q <= 1'b1;
				default:          pend_q   <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			slat_pkg::ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
				end
			end
			slat_pkg::ST_SCAN: begin
				if (pend_q && key_ge) begin
					pos_q <= CW'(wa_q);
					ent_q <= rdata;
				end else if (!pend_q && !issue) begin
					pos_q <= cnt_q;
				end
			end
			slat_pkg::ST_FIN: begin
				res_q.found        <= hit_q;
				res_q.full_drop    <= drop_q;
				res_q.entries_used <= 7'(cnt_q);
				res_q.count_out    <= 16'd0;
				if (hit_q && cmd_q.op == slat_pkg::OP_GET_BEFORE) begin
					res_q.count_out <= ent_q.before_cnt;
				end
				if (hit_q && cmd_q.op == slat_pkg::OP_GET_AFTER) begin
					res_q.count_out <= ent_q.after_cnt;
				end
			end
			default: res_q <= res_q;
		endcase
		wa_q <= idx_q[AW-1:0];
	end

	assign busy   = state_q != slat_pkg::ST_IDLE;
	assign strobe = strobe_q;
	assign result = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_strobe_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == slat_pkg::ST_FIN))
		else $error("result strobe without finishing a transaction");

	a_shup_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slat_pkg::ST_SHUP |-> cnt_q < CW'(CAPACITY) && !hit_q)
		else $error("insert shift into full table or onto an existing key");

	a_shdn_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slat_pkg::ST_SHDN |-> hit_q && cnt_q != '0 && pos_q < cnt_q)
		else $error("removal without a matching entry");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slat_pkg::ST_FIN && drop_q) |-> cnt_q == CW'(CAPACITY))
		else $error("drop flagged with room in table");

endmodule

`default_nettype wire

@@ rtl/slat_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slat_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire slat_pkg::entry_t      wdata,
	input  wire logic [AW-1:0]         raddr,
	output slat_pkg::entry_t           rdata
);

	slat_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int TBL_DEPTH = 64;
	localparam int POOL_SIZE = 96;
	localparam int TAIL_CYCLES = 2 * TBL_DEPTH + 20;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SHOW_LIMIT = 10;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	slat_pkg::in_t cmd = '0;
	logic busy;
	logic strobe;
	slat_pkg::out_t result;

	sorted_line_attribute_table #(.CAPACITY(TBL_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table
	logic [15:0] line_keys [TBL_DEPTH];
	logic [15:0] before_cnts [TBL_DEPTH];
	logic [15:0] after_cnts [TBL_DEPTH];
	int lines_held = 0;

	slat_pkg::out_t pending_results [$];
	logic [15:0] key_pool [POOL_SIZE];
	int max_gap = 9;
	int err_cnt = 0;
	int cycle_cnt = 0;
	slat_pkg::out_t want;

	function automatic void drop_line(input int pos);
		int i;
		for (i = pos; i + 1 < lines_held; i++) begin
			line_keys[i] = line_keys[i + 1];
			before_cnts[i] = before_cnts[i + 1];
			after_cnts[i] = after_cnts[i + 1];
		end
		lines_held--;
	endfunction

	function automatic slat_pkg::out_t apply_line_op(input slat_pkg::in_t c);
		slat_pkg::out_t r;
		int i;
		int pos;
		int slot;
		bit hit;
		r = '0;
		pos = 0;
		hit = 1'b0;
		if (c.op <= slat_pkg::OP_RESET_AFTER) begin
			for (i = 0; i < lines_held; i++) begin
				if (!hit && line_keys[i] == c.line_key) begin
					hit = 1'b1;
					pos = i;
				end
			end
		end
		case (slat_pkg::op_e'(c.op))
			slat_pkg::OP_INSERT: begin
				if (hit) begin
					if (c.before_in != 16'd0) before_cnts[pos] = c.before_in;
					if (c.after_in != 16'd0) after_cnts[pos] = c.after_in;
				end else if (lines_held >= TBL_DEPTH) begin
					r.full_drop = 1'b1;
				end else begin
					slot = 0;
					for (i = 0; i < lines_held; i++)
						if (line_keys[i] < c.line_key) slot++;
					for (i = lines_held; i > slot; i--) begin
						line_keys[i] = line_keys[i - 1];
						before_cnts[i] = before_cnts[i - 1];
						after_cnts[i] = after_cnts[i - 1];
					end
					line_keys[slot] = c.line_key;
					before_cnts[slot] = c.before_in;
					after_cnts[slot] = c.after_in;
					lines_held++;
				end
			end
			slat_pkg::OP_DELETE: begin
				if (hit) drop_line(pos);
			end
			slat_pkg::OP_GET_BEFORE: begin
				if (hit) r.count_out = before_cnts[pos];
			end
			slat_pkg::OP_GET_AFTER: begin
				if (hit) r.count_out = after_cnts[pos];
			end
			slat_pkg::OP_RESET_BEFORE: begin
				if (hit) begin
					before_cnts[pos] = 16'd0;
					if (after_cnts[pos] == 16'd0) drop_line(pos);
				end
			end
			slat_pkg::OP_RESET_AFTER: begin
				if (hit) begin
					after_cnts[pos] = 16'd0;
					if (before_cnts[pos] == 16'd0) drop_line(pos);
				end
			end
			default: begin
			end
		endcase
		r.found = hit;
		r.entries_used = lines_held[6:0];
		return r;
	endfunction

	function automatic slat_pkg::in_t mk_cmd(input logic [2:0] op, input logic [15:0] key,
			input logic [15:0] bef, input logic [15:0] aft);
		slat_pkg::in_t c;
		c.op = op;
		c.line_key = key;
		c.before_in = bef;
		c.after_in = aft;
		return c;
	endfunction

	function automatic logic [15:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 95) return 16'($urandom);
		return r[0] ? 16'hffff : 16'h0000;
	endfunction

	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return 16'h0000;
		if (r < 35) return 16'hffff;
		return 16'($urandom);
	endfunction

	function automatic slat_pkg::in_t pick_line_op();
		int r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (r < 40) op = slat_pkg::OP_INSERT;
		else if (r < 52) op = slat_pkg::OP_DELETE;
		else if (r < 64) op = slat_pkg::OP_GET_BEFORE;
		else if (r < 76) op = slat_pkg::OP_GET_AFTER;
		else if (r < 86) op = slat_pkg::OP_RESET_BEFORE;
		else if (r < 96) op = slat_pkg::OP_RESET_AFTER;
		else op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
		return mk_cmd(op, pick_key(), pick_count(), pick_count());
	endfunction

	task automatic send_cmd(input slat_pkg::in_t c);
		int gap;
		gap = $urandom_range(0, max_gap);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(apply_line_op(c));
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= SHOW_LIMIT)
					$display("unexpected transaction: found=%0d count=%h drop=%0d used=%0d",
						result.found, result.count_out, result.full_drop,
						result.entries_used);
			end else begin
				want = pending_results.pop_front();
				if (result.found !== want.found || result.count_out !== want.count_out ||
						result.full_drop !== want.full_drop ||
						result.entries_used !== want.entries_used) begin
					err_cnt++;
					if (err_cnt <= SHOW_LIMIT)
						$display("mismatch: exp %0d %h %0d %0d act %0d %h %0d %0d",
							want.found, want.count_out, want.full_drop, want.entries_used,
							result.found, result.count_out, result.full_drop,
							result.entries_used);
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic test_directed_ops();
		send_cmd(mk_cmd(slat_pkg::OP_GET_BEFORE, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_DELETE, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h8000, 16'h0005, 16'h0007));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h0000, 16'hffff, 16'hffff));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'hffff, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h1234, 16'h0001, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_BEFORE, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_AFTER, 16'hffff, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_AFTER, 16'h8000, 16'h0000, 16'h0000));
		// merge: only nonzero counts overwrite
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h8000, 16'h0000, 16'h0009));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_BEFORE, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_AFTER, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_RESET_BEFORE, 16'h1234, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_BEFORE, 16'h1234, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_RESET_AFTER, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_RESET_BEFORE, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_RESET_AFTER, 16'hffff, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_RESET_BEFORE, 16'h4321, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(OP_SPARE_6, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(OP_SPARE_7, 16'hffff, 16'hffff, 16'hffff));
		send_cmd(mk_cmd(slat_pkg::OP_DELETE, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_GET_AFTER, 16'h8000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'haaaa, 16'h5555, 16'haaaa));
		send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'h5555, 16'haaaa, 16'h5555));
	endtask

	task automatic test_full_table();
		int i;
		logic [15:0] key;
		while (lines_held < TBL_DEPTH)
			send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'($urandom), pick_count(), pick_count()));
		for (i = 0; i < 40; i++) begin
			key = line_keys[$urandom_range(0, lines_held - 1)];
			case ($urandom_range(0, 3))
				0: send_cmd(mk_cmd(slat_pkg::OP_INSERT, 16'($urandom), pick_count(),
					pick_count()));
				1: send_cmd(mk_cmd(slat_pkg::OP_INSERT, key, pick_count(), pick_count()));
				2: send_cmd(mk_cmd(slat_pkg::OP_GET_BEFORE, key, 16'h0000, 16'h0000));
				default: send_cmd(mk_cmd(slat_pkg::OP_GET_AFTER, key, 16'h0000, 16'h0000));
			endcase
		end
		while (lines_held > 0) begin
			key = line_keys[$urandom_range(0, lines_held - 1)];
			case ($urandom_range(0, 2))
				0: send_cmd(mk_cmd(slat_pkg::OP_DELETE, key, 16'h0000, 16'h0000));
				1: send_cmd(mk_cmd(slat_pkg::OP_RESET_BEFORE, key, 16'h0000, 16'h0000));
				default: send_cmd(mk_cmd(slat_pkg::OP_RESET_AFTER, key, 16'h0000,
					16'h0000));
			endcase
		end
	endtask

	task automatic test_random_mix(input int n_items);
		int i;
		for (i = 0; i < n_items; i++) begin
			if (i % 100 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
			if (i == n_items / 2) drain_results();
			send_cmd(pick_line_op());
		end
		max_gap = 9;
	endtask

	initial begin
		int i;
		for (i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hffff;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_full_table();
		test_random_mix(1250);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
